// ===== src/i2cbs_pkg.sv =====
`default_nettype none
package i2cbs_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_W         = $clog2(BITS_PER_BYTE);
	localparam int STEP_W        = 5;
	localparam int HOLD_W        = 16;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd720;

	localparam logic [BIT_W-1:0] BIT_MSB = BIT_W'(BITS_PER_BYTE - 1);

	localparam logic [STEP_W-1:0] LAST_START = 5'd3;
	localparam logic [STEP_W-1:0] LAST_STOP  = 5'd3;
	localparam logic [STEP_W-1:0] LAST_WRITE = 5'd23;
	localparam logic [STEP_W-1:0] LAST_READ  = 5'd25;
	localparam logic [STEP_W-1:0] LAST_SACK  = 5'd2;
	localparam logic [STEP_W-1:0] LAST_RACK  = 5'd3;

	// phases before the bit loop of read byte
	localparam logic [STEP_W-1:0] READ_HDR = 5'd2;

	typedef enum logic [2:0] {
		KIND_START = 3'd0,
		KIND_STOP  = 3'd1,
		KIND_WRITE = 3'd2,
		KIND_READ  = 3'd3,
		KIND_SACK  = 3'd4,
		KIND_RACK  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		SUB_LOW  = 2'd0,
		SUB_MID  = 2'd1,
		SUB_HIGH = 2'd2
	} sub_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        tx_byte;
		logic              ack_level;
		logic [7:0]        rx_line_bits;
		logic [STEP_W-1:0] last_idx;
		logic [7:0]        read_value;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sample_now;
		logic       sampled_bit;
		logic [7:0] read_value;
		logic       last_phase;
	} phase_t;

endpackage
`default_nettype wire

// ===== src/i2cbs_fifo.sv =====
`default_nettype none
module i2cbs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full      = (cnt_q == CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/i2cbs_front.sv =====
`default_nettype none
module i2cbs_front (
	input  wire logic [2:0]   kind,
	input  wire logic [7:0]   tx_byte,
	input  wire logic         ack_level,
	input  wire logic [7:0]   rx_line_bits,
	output logic              cmd_ok,
	output i2cbs_pkg::cmd_t   cmd
);
	import i2cbs_pkg::*;

	always_comb begin
		cmd.kind         = kind_t'(kind);
		cmd.tx_byte      = tx_byte;
		cmd.ack_level    = ack_level;
		cmd.rx_line_bits = rx_line_bits;
		cmd.last_idx     = '0;
		cmd.read_value   = '0;
		cmd_ok           = 1'b1;
		unique case (kind)
			KIND_START: cmd.last_idx = LAST_START;
			KIND_STOP:  cmd.last_idx = LAST_STOP;
			KIND_WRITE: cmd.last_idx = LAST_WRITE;
			KIND_READ: begin
				cmd.last_idx   = LAST_READ;
				cmd.read_value = rx_line_bits;
			end
			KIND_SACK:  cmd.last_idx = LAST_SACK;
			KIND_RACK: begin
				cmd.last_idx   = LAST_RACK;
				cmd.read_value = {7'd0, rx_line_bits[7]};
			end
			default:    cmd_ok = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/i2cbs_back.sv =====
`default_nettype none
module i2cbs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [i2cbs_pkg::HOLD_W-1:0]  hold,
	input  wire logic                          cmd_avail,
	input  wire i2cbs_pkg::cmd_t               cmd_in,
	output logic                               cmd_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output i2cbs_pkg::phase_t                  out_phase
);
	import i2cbs_pkg::*;

	bk_state_t         state_q, state_d;
	cmd_t              cur_q;
	logic [STEP_W-1:0] step_q;
	sub_t              sub_q;
	logic [BIT_W-1:0]  bit_q;
	logic [HOLD_W-1:0] wait_q;
	logic              scl_q, sda_q;
	logic              valid_q;
	phase_t            phase_q;

	logic emit, last, load, adv_bits;
	logic op_scl, op_sda, op_smp, op_val;
	logic tx_bit, rx_bit;
	phase_t phase_d;

	assign tx_bit   = cur_q.tx_byte[BIT_MSB - bit_q];
	assign rx_bit   = cur_q.rx_line_bits[BIT_MSB - bit_q];
	assign last     = (step_q == cur_q.last_idx);
	assign adv_bits = (cur_q.kind == KIND_WRITE) ||
	                  ((cur_q.kind == KIND_READ) && (step_q >= READ_HDR));

	always_comb begin
		op_scl = 1'b0;
		op_sda = 1'b0;
		op_smp = 1'b0;
		op_val = 1'b0;
		unique case (cur_q.kind) inside
			KIND_START, KIND_STOP, KIND_RACK: begin
				case (step_q[1:0])
					2'd0: op_scl = 1'b1;
					2'd1: begin
						op_sda = 1'b1;
						op_val = (cur_q.kind != KIND_STOP);
					end
					2'd2: begin
						op_scl = 1'b1;
						op_val = 1'b1;
					end
					default: begin
						if (cur_q.kind == KIND_RACK) begin
							op_smp = 1'b1;
							op_val = cur_q.rx_line_bits[7];
						end else begin
							op_sda = 1'b1;
							op_val = (cur_q.kind == KIND_STOP);
						end
					end
				endcase
			end
			KIND_SACK: begin
				case (step_q[1:0])
					2'd0:    op_scl = 1'b1;
					2'd1: begin
						op_sda = 1'b1;
						op_val = cur_q.ack_level;
					end
					default: begin
						op_scl = 1'b1;
						op_val = 1'b1;
					end
				endcase
			end
			KIND_WRITE: begin
				case (sub_q)
					SUB_LOW: op_scl = 1'b1;
					SUB_MID: begin
						op_sda = 1'b1;
						op_val = tx_bit;
					end
					default: begin
						op_scl = 1'b1;
						op_val = 1'b1;
					end
				endcase
			end
			KIND_READ: begin
				if (step_q == '0) begin
					op_scl = 1'b1;
				end else if (step_q < READ_HDR) begin
					op_sda = 1'b1;
					op_val = 1'b1;
				end else begin
					case (sub_q)
						SUB_LOW: op_scl = 1'b1;
						SUB_MID: begin
							op_scl = 1'b1;
							op_val = 1'b1;
						end
						default: begin
							op_smp = 1'b1;
							op_val = rx_bit;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		phase_d.scl_level   = op_scl ? op_val : scl_q;
		phase_d.sda_level   = op_sda ? op_val : sda_q;
		phase_d.sample_now  = op_smp;
		phase_d.sampled_bit = op_smp & op_val;
		phase_d.read_value  = last ? cur_q.read_value : 8'd0;
		phase_d.last_phase  = last;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (cmd_avail) state_d = BK_RUN;
			BK_RUN:  if (emit && last && !cmd_avail) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		load = 1'b0;
		unique case (state_q)
			BK_IDLE: load = cmd_avail;
			BK_RUN: begin
				emit = (wait_q == '0) && (!valid_q || out_ready);
				load = emit && last && cmd_avail;
			end
			default: ;
		endcase
	end

	assign cmd_pop   = load;
	assign out_valid = valid_q;
	assign out_phase = phase_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd_in;
		end
		if (emit) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
			sub_q   <= SUB_LOW;
			bit_q   <= '0;
			wait_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (emit) begin
				scl_q  <= phase_d.scl_level;
				sda_q  <= phase_d.sda_level;
				wait_q <= (hold == '0) ? '0 : hold - 1'b1;
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
			if (load) begin
				step_q <= '0;
				sub_q  <= SUB_LOW;
				bit_q  <= '0;
			end else if (emit) begin
				step_q <= step_q + 1'b1;
				if (adv_bits) begin
					if (sub_q == SUB_HIGH) begin
						sub_q <= SUB_LOW;
						bit_q <= bit_q + 1'b1;
					end else begin
						sub_q <= sub_t'(sub_q + 2'd1);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tuser kind, tdata tx_byte, ack_level, rx_line_bits
// m_*      out  m_tvalid/m_tready   tdata phase fields + read_value, tlast last_phase
// cfg_*    in   cfg_valid/cfg_ready cfg_data phase_hold_cycles, always ready
//
// One item per bus phase, spaced by the back end hold counter (phase_hold_cycles) and
// stalled by m_tready. A command takes 3..26 phases (read byte 26).
// Commands queue in a FIFO_DEPTH entry FIFO; s_tready drops only when it is full.
// Unused kinds are accepted and produce no items. Reset releases SCL and SDA.
`default_nettype none
module i2c_master_bit_sequencer #(
	parameter int FIFO_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // tx_byte[7:0], ack_level[8], rx_line_bits[16:9]
	input  wire logic [2:0]  s_tuser,   // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // scl_level[0], sda_level[1], sample_now[2],
	                                    // sampled_bit[3], read_value[11:4]
	output logic             m_tlast,   // last_phase
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import i2cbs_pkg::*;

	logic [HOLD_W-1:0] hold_q;
	cmd_t   dec_cmd, q_cmd;
	logic   dec_ok, q_full, q_avail, q_pop;
	phase_t ph;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_valid) begin
			hold_q <= cfg_data;
		end
	end

	i2cbs_front u_front (
		.kind         (s_tuser),
		.tx_byte      (s_tdata[7:0]),
		.ack_level    (s_tdata[8]),
		.rx_line_bits (s_tdata[16:9]),
		.cmd_ok       (dec_ok),
		.cmd          (dec_cmd)
	);

	i2cbs_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid & dec_ok),
		.push_data (dec_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_cmd),
		.not_empty (q_avail)
	);

	i2cbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (hold_q),
		.cmd_avail (q_avail),
		.cmd_in    (q_cmd),
		.cmd_pop   (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_phase (ph)
	);

	assign m_tdata = {4'd0, ph.read_value, ph.sampled_bit, ph.sample_now,
	                  ph.sda_level, ph.scl_level};
	assign m_tlast = ph.last_phase;
endmodule
`default_nettype wire
